/* rtl/core/infix_to_postfix_converter_unit_macros.svh */
// Assertion macros for the infix to postfix converter.
// Included by the top level; depends on nothing else.
`ifndef INFIX_TO_POSTFIX_CONVERTER_UNIT_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ITP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ITP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/itp_pkg.sv */
// Shared types, constants and helper functions for the infix to postfix converter.
// Used by the sequencer, the output buffer and the top level; depends on nothing.
package itp_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int MAX_RESULTS = 32;
    localparam int CODE_W      = 3;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;

    typedef enum logic [CODE_W-1:0] {
        OP_LPAREN = 3'd0,
        OP_ADD    = 3'd1,
        OP_SUB    = 3'd2,
        OP_MUL    = 3'd3,
        OP_DIV    = 3'd4
    } t_op_code;

    typedef enum logic [1:0] {
        ST_OK              = 2'd0,
        ST_OVERFLOW        = 2'd1,
        ST_UNMATCHED_CLOSE = 2'd2,
        ST_UNMATCHED_OPEN  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_PUSH,
        S_TAIL,
        S_FLUSH
    } t_state;

    typedef enum logic [1:0] {
        K_FINISH,
        K_CLOSE,
        K_OP
    } t_kind;

    // Result request from the sequencer to the output buffer.
    typedef struct packed {
        logic       emit;
        logic       flush;
        logic [7:0] ch;
        logic       cv;
        t_status    st;
    } t_emit;

    // Stack memory access.
    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [ADDR_W-1:0] addr;
        logic [CODE_W-1:0] wdata;
    } t_ram_req;

    function automatic logic [1:0] code_rank(input logic [CODE_W-1:0] code);
        logic [1:0] rank;
        case (code)
            OP_MUL, OP_DIV: rank = 2'd2;
            OP_LPAREN:      rank = 2'd0;
            default:        rank = 2'd1;
        endcase
        return rank;
    endfunction

    function automatic logic [7:0] code_char(input logic [CODE_W-1:0] code);
        logic [7:0] ch;
        case (code)
            OP_ADD:  ch = CH_PLUS;
            OP_SUB:  ch = CH_MINUS;
            OP_MUL:  ch = CH_STAR;
            OP_DIV:  ch = CH_SLASH;
            default: ch = CH_LPAR;
        endcase
        return ch;
    endfunction

    function automatic t_op_code char_code(input logic [7:0] ch);
        t_op_code code;
        case (ch)
            CH_PLUS:  code = OP_ADD;
            CH_MINUS: code = OP_SUB;
            CH_STAR:  code = OP_MUL;
            CH_SLASH: code = OP_DIV;
            default:  code = OP_LPAREN;
        endcase
        return code;
    endfunction

endpackage

/* rtl/core/itp_stack_ram.sv */
// Single-port synchronous RAM with registered read data.
// Holds the operator stack; generic, no package dependency.
module itp_stack_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 3
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
        // read data holds until the next read
        if (i_rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/itp_ctrl.sv */
// Sequencer for the shunting-yard converter: decodes items, walks the stack.
// Depends on itp_pkg; drives the stack RAM and the output buffer.
module itp_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_command,
    input  logic [7:0]                 i_token_char,
    output logic                       o_in_ready,
    input  logic                       i_step_ok,
    input  logic [itp_pkg::CODE_W-1:0] i_rd_data,
    output itp_pkg::t_ram_req          o_ram,
    output itp_pkg::t_emit             o_emit,
    output logic [itp_pkg::CNT_W-1:0]  o_count
);

    import itp_pkg::*;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count;
    logic [RES_CNT_W-1:0]  r_res_cnt;
    t_kind                 r_kind;
    t_op_code              r_code;
    t_status               r_tail;

    logic       w_accept, w_alnum, w_lpar, w_rpar, w_op;
    t_op_code   w_top;
    logic       w_top_lp, w_pop_stop, w_last_pop, w_full, w_room;
    logic       w_emit_req, w_dec, w_inc, w_set_open;
    logic [CNT_W-1:0] w_count_m1;

    assign w_accept = i_in_valid && o_in_ready;
    assign w_alnum  = ((i_token_char >= CH_0)  && (i_token_char <= CH_9))  ||
                      ((i_token_char >= CH_LA) && (i_token_char <= CH_LZ)) ||
                      ((i_token_char >= CH_UA) && (i_token_char <= CH_UZ));
    assign w_lpar   = (i_token_char == CH_LPAR);
    assign w_rpar   = (i_token_char == CH_RPAR);
    assign w_op     = (i_token_char == CH_PLUS) || (i_token_char == CH_MINUS) ||
                      (i_token_char == CH_STAR) || (i_token_char == CH_SLASH);

    assign w_top      = t_op_code'(i_rd_data);
    assign w_top_lp   = (w_top == OP_LPAREN);
    assign w_pop_stop = w_top_lp || (code_rank(w_top) < code_rank(r_code));
    assign w_last_pop = (r_count == CNT_W'(1));
    assign w_full     = (r_count == CNT_W'(STACK_DEPTH));
    assign w_count_m1 = r_count - CNT_W'(1);
    // drop results beyond the per-item limit
    assign w_room     = (r_state == S_IDLE) || (r_res_cnt < RES_CNT_W'(MAX_RESULTS));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_command) begin
                        n_state = (r_count == '0) ? S_FLUSH : S_READ;
                    end else if (w_alnum) begin
                        n_state = S_FLUSH;
                    end else if (w_lpar) begin
                        n_state = S_PUSH;
                    end else if (w_rpar) begin
                        n_state = (r_count == '0) ? S_FLUSH : S_READ;
                    end else if (w_op) begin
                        n_state = (r_count == '0) ? S_PUSH : S_READ;
                    end
                end
            end
            S_READ: n_state = S_EVAL;
            S_EVAL: begin
                if (i_step_ok) begin
                    unique case (r_kind)
                        K_FINISH: n_state = w_last_pop ? S_TAIL : S_READ;
                        K_CLOSE: begin
                            if (w_top_lp) begin
                                n_state = S_FLUSH;
                            end else begin
                                n_state = w_last_pop ? S_TAIL : S_READ;
                            end
                        end
                        default: begin
                            if (w_pop_stop || w_last_pop) begin
                                n_state = S_PUSH;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                    endcase
                end
            end
            S_PUSH:  if (i_step_ok) n_state = S_FLUSH;
            S_TAIL:  if (i_step_ok) n_state = S_FLUSH;
            S_FLUSH: if (i_step_ok) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready   = 1'b0;
        o_ram.rd_en  = 1'b0;
        o_ram.wr_en  = 1'b0;
        o_ram.addr   = w_count_m1[ADDR_W-1:0];
        o_ram.wdata  = r_code;
        w_emit_req   = 1'b0;
        o_emit.flush = 1'b0;
        o_emit.ch    = '0;
        o_emit.cv    = 1'b0;
        o_emit.st    = ST_OK;
        w_dec        = 1'b0;
        w_inc        = 1'b0;
        w_set_open   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (w_accept && !i_command) begin
                    if (w_alnum) begin
                        w_emit_req = 1'b1;
                        o_emit.ch  = i_token_char;
                        o_emit.cv  = 1'b1;
                    end else if (w_rpar && (r_count == '0)) begin
                        w_emit_req = 1'b1;
                        o_emit.st  = ST_UNMATCHED_CLOSE;
                    end
                end
            end
            S_READ: o_ram.rd_en = 1'b1;
            S_EVAL: begin
                if (i_step_ok) begin
                    o_emit.ch = code_char(w_top);
                    o_emit.cv = 1'b1;
                    unique case (r_kind)
                        K_FINISH: begin
                            w_dec      = 1'b1;
                            w_set_open = w_top_lp;
                            w_emit_req = !w_top_lp;
                        end
                        K_CLOSE: begin
                            w_dec      = 1'b1;
                            w_emit_req = !w_top_lp;
                        end
                        default: begin
                            w_dec      = !w_pop_stop;
                            w_emit_req = !w_pop_stop;
                        end
                    endcase
                end
            end
            S_PUSH: begin
                o_ram.addr = r_count[ADDR_W-1:0];
                if (i_step_ok) begin
                    if (w_full) begin
                        w_emit_req = 1'b1;
                        o_emit.st  = ST_OVERFLOW;
                    end else begin
                        o_ram.wr_en = 1'b1;
                        w_inc       = 1'b1;
                    end
                end
            end
            S_TAIL: begin
                if (i_step_ok && (r_tail != ST_OK)) begin
                    w_emit_req = 1'b1;
                    o_emit.st  = r_tail;
                end
            end
            S_FLUSH: o_emit.flush = i_step_ok;
            default: ;
        endcase
        o_emit.emit = w_emit_req && w_room;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_res_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (w_dec) begin
                r_count <= w_count_m1;
            end else if (w_inc) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (w_accept) begin
                r_res_cnt <= o_emit.emit ? RES_CNT_W'(1) : '0;
            end else if (o_emit.emit) begin
                r_res_cnt <= r_res_cnt + RES_CNT_W'(1);
            end
        end
    end

    // item payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_code <= char_code(i_token_char);
            if (i_command) begin
                r_kind <= K_FINISH;
                r_tail <= ST_OK;
            end else begin
                r_kind <= w_rpar ? K_CLOSE : K_OP;
                r_tail <= ST_UNMATCHED_CLOSE;
            end
        end else if (w_set_open) begin
            r_tail <= ST_UNMATCHED_OPEN;
        end
    end

    assign o_count = r_count;

endmodule

/* rtl/core/itp_out_buf.sv */
// Result buffer: one pending result plus the output register.
// Depends on itp_pkg; marks the final result of an item when it is flushed.
module itp_out_buf (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  itp_pkg::t_emit i_emit,
    output logic           o_step_ok,
    output logic           o_pend_valid,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output logic [7:0]     o_out_char,
    output logic           o_char_valid,
    output logic [1:0]     o_status,
    output logic           o_last
);

    import itp_pkg::*;

    logic       r_pend_valid;
    logic [7:0] r_pend_ch;
    logic       r_pend_cv;
    t_status    r_pend_st;

    logic       r_out_valid;
    logic [7:0] r_out_ch;
    logic       r_out_cv;
    t_status    r_out_st;
    logic       r_out_last;

    logic w_out_free, w_load;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_step_ok  = !r_pend_valid || w_out_free;
    // pending result moves out when a newer one arrives or the item ends
    assign w_load     = r_pend_valid && (i_emit.emit || i_emit.flush);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_emit.emit) begin
                r_pend_valid <= 1'b1;
            end else if (i_emit.flush) begin
                r_pend_valid <= 1'b0;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_emit.emit) begin
            r_pend_ch <= i_emit.ch;
            r_pend_cv <= i_emit.cv;
            r_pend_st <= i_emit.st;
        end
        if (w_load) begin
            r_out_ch   <= r_pend_ch;
            r_out_cv   <= r_pend_cv;
            r_out_st   <= r_pend_st;
            r_out_last <= i_emit.flush;
        end
    end

    assign o_pend_valid = r_pend_valid;
    assign o_out_valid  = r_out_valid;
    assign o_out_char   = r_out_ch;
    assign o_char_valid = r_out_cv;
    assign o_status     = 2'(r_out_st);
    assign o_last       = r_out_last;

endmodule

/* rtl/core/infix_to_postfix_converter_unit.sv */
// Shunting-yard infix to postfix converter, top level.
// Depends on itp_pkg, itp_stack_ram, itp_ctrl, itp_out_buf and the macros header.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready): one item per handshake, either a
//   character (i_command = 0, i_token_char) or a finish command (i_command = 1).
//   Output channel (o_out_valid / i_out_ready): zero or more result items per
//   input item; o_last marks the final one. Status-only results carry
//   o_char_valid = 0 and a nonzero o_status.
// Timing:
//   o_in_ready is high only while the sequencer is idle; one item is worked on
//   at a time. Letters and digits are emitted at accept and released by a
//   flush step. Each stack pop is a RAM read, then an evaluate step; a push or
//   tail step may follow, and a last flush step releases the final result. The
//   steps after the read wait while the output is blocked. Unknown characters
//   are dropped at accept with no result.
// Reset:
//   Synchronous, active low: the stack is empty and no result is pending.
//   The stack RAM is not cleared; only entries below the count are read.
// Back-pressure:
//   One result is held pending so the final one can be tagged; when the output
//   register is full and not taken, the sequencer holds until it drains.
module infix_to_postfix_converter_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_command,
    input  logic [7:0] i_token_char,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_char,
    output logic       o_char_valid,
    output logic [1:0] o_status,
    output logic       o_last
);

    import itp_pkg::*;

`include "infix_to_postfix_converter_unit_macros.svh"

    t_ram_req          w_ram;
    t_emit             w_emit;
    logic [CODE_W-1:0] w_rd_data;
    logic [CNT_W-1:0]  w_count;
    logic              w_step_ok;
    logic              w_pend_valid;

    // operator stack storage
    itp_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (CODE_W)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rd_en (w_ram.rd_en),
        .i_wr_en (w_ram.wr_en),
        .i_addr  (w_ram.addr),
        .i_wdata (w_ram.wdata),
        .o_rdata (w_rd_data)
    );

    // decode items, walk the stack, request results
    itp_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_command    (i_command),
        .i_token_char (i_token_char),
        .o_in_ready   (o_in_ready),
        .i_step_ok    (w_step_ok),
        .i_rd_data    (w_rd_data),
        .o_ram        (w_ram),
        .o_emit       (w_emit),
        .o_count      (w_count)
    );

    // hold one result back to tag the last, then register it out
    itp_out_buf u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_emit       (w_emit),
        .o_step_ok    (w_step_ok),
        .o_pend_valid (w_pend_valid),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_out_char   (o_out_char),
        .o_char_valid (o_char_valid),
        .o_status     (o_status),
        .o_last       (o_last)
    );

    `ITP_ASSERT_IMPLY(a_idle_no_pend, i_clk, i_rst_n, o_in_ready, !w_pend_valid,
                      "pending result while idle")
    `ITP_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1, w_count <= CNT_W'(STACK_DEPTH),
                      "stack count beyond depth")
    `ITP_ASSERT_IMPLY(a_emit_gated, i_clk, i_rst_n, w_emit.emit || w_emit.flush, w_step_ok,
                      "result requested while output blocked")
    `ITP_ASSERT_IMPLY(a_ram_excl, i_clk, i_rst_n, w_ram.wr_en, !w_ram.rd_en,
                      "stack read and write in one cycle")

endmodule
